/* design/assert_macros.svh */
// Assertion macros used by the checker file of the sentence framer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NSF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sentence framer check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define NSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sentence framer check failed");

`endif

/* design/nsf_pkg.sv */
// Types, characters and helper functions of the NMEA sentence framer.
package nsf_pkg;

  localparam int unsigned HEAD_DEPTH = 6;
  localparam int unsigned HEAD_LEN_W = 3;
  localparam int unsigned KIND_W     = 3;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef logic [HEAD_DEPTH-1:0][7:0] head_t;
  typedef logic [1:0][7:0]            sum_chars_t;

  // "$GPRMC" and "$GPGGA", first character at index 0.
  localparam head_t HDR_RMC = {8'h43, 8'h4D, 8'h52, 8'h50, 8'h47, 8'h24};
  localparam head_t HDR_GGA = {8'h41, 8'h47, 8'h47, 8'h50, 8'h47, 8'h24};

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BODY  = 2'd1,
    PH_SUM   = 2'd2,
    PH_CLOSE = 2'd3
  } phase_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_RMC      = 3'd0,
    KIND_GGA      = 3'd1,
    KIND_OTHER    = 3'd2,
    KIND_BAD_SUM  = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_e;

  // Value of one hex digit in either case; anything else counts as zero.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

/* design/nmea_sentence_framer_top.sv */
// Top level of the NMEA sentence framer: byte intake, framing state and result register.
//
// The framer takes one received UART character per clock unless stalled and frames NMEA
// 0183 sentences: a sentence opens on '$', body bytes (commas included) fold into a running
// XOR and each comma counts a field, up to two checksum characters after '*' are kept until
// CR, and the byte that follows CR closes the sentence with one result transaction carrying
// the kind (RMC, GGA, other, bad checksum, overflow), both checksums and the sticky
// bad-checksum flag. A sentence that reaches MAX_FIELDS-1 fields or MAX_CHARS-1 characters
// in one field gives an overflow result on its next byte, which is dropped. A byte is taken
// into an input register and handled by the framing logic from there, so the block sustains
// one byte per clock while not stalled; a result is registered in the output register when
// its closing byte is handled from the input register. The only thing that holds the input
// back is a byte that would produce a result while the output register still holds an
// untaken result; bytes that give no result keep flowing even while the output side stalls.
module nmea_sentence_framer_top #(
  parameter int unsigned MAX_FIELDS = 32,
  parameter int unsigned MAX_CHARS  = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rx_valid_i,
  output logic                      rx_stall_o,
  input  logic [7:0]                rx_byte_i,
  output logic                      res_valid_o,
  input  logic                      res_stall_i,
  output logic [nsf_pkg::KIND_W-1:0] sentence_kind_o,
  output logic [7:0]                computed_sum_o,
  output logic [7:0]                received_sum_o,
  output logic                      checksum_error_sticky_o
);
  import nsf_pkg::*;

  localparam int unsigned FIELD_W = $clog2(MAX_FIELDS);
  localparam int unsigned CHAR_W  = $clog2(MAX_CHARS);

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Framing state.
  phase_e                phase_q, phase_d;
  logic [FIELD_W-1:0]    field_index_q, field_index_d;
  logic [CHAR_W-1:0]     char_pos_q, char_pos_d;
  logic [7:0]            running_xor_q, running_xor_d;
  sum_chars_t            sum_chars_q, sum_chars_d;
  head_t                 head_chars_q, head_chars_d;
  logic [HEAD_LEN_W-1:0] head_length_q, head_length_d;
  logic                  bad_sum_q, bad_sum_d;

  // Result register.
  logic              out_valid_q;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [7:0]        csum_q;
  logic [7:0]        rsum_q, rsum_d;

  logic overflow;
  logic gives_result;
  logic out_free;
  logic fire;
  logic rx_accept;

  // An overflow or a closing byte produces a result; both depend on state only.
  assign overflow = (field_index_q == FIELD_W'(MAX_FIELDS - 1)) ||
                    (char_pos_q == CHAR_W'(MAX_CHARS - 1));
  assign gives_result = overflow || (phase_q == PH_CLOSE);

  assign out_free   = !out_valid_q || !res_stall_i;
  assign fire       = in_valid_q && (!gives_result || out_free);
  assign rx_stall_o = in_valid_q && !fire;
  assign rx_accept  = rx_valid_i && !rx_stall_o;

  always_comb begin
    logic keep_head;
    logic [7:0] b;
    logic [7:0] rsum;

    b             = in_byte_q;
    keep_head     = 1'b0;
    rsum          = {hex_val(sum_chars_q[0]), hex_val(sum_chars_q[1])};
    phase_d       = phase_q;
    field_index_d = field_index_q;
    char_pos_d    = char_pos_q;
    running_xor_d = running_xor_q;
    sum_chars_d   = sum_chars_q;
    head_chars_d  = head_chars_q;
    head_length_d = head_length_q;
    bad_sum_d     = bad_sum_q;
    kind_d        = KIND_OVERFLOW;
    rsum_d        = 8'd0;

    if (overflow) begin
      kind_d = KIND_OVERFLOW;
      rsum_d = 8'd0;
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          if (b == CH_START) begin
            keep_head     = 1'b1;
            char_pos_d    = CHAR_W'(1);
            running_xor_d = 8'd0;
            phase_d       = PH_BODY;
          end
        end
        PH_BODY: begin
          if (b == CH_COMMA) begin
            field_index_d = field_index_q + FIELD_W'(1);
            char_pos_d    = '0;
            running_xor_d = running_xor_q ^ b;
          end else if (b == CH_STAR) begin
            phase_d       = PH_SUM;
            field_index_d = field_index_q + FIELD_W'(1);
            char_pos_d    = '0;
          end else begin
            running_xor_d = running_xor_q ^ b;
            keep_head     = (field_index_q == '0);
            char_pos_d    = char_pos_q + CHAR_W'(1);
          end
        end
        PH_SUM: begin
          if (char_pos_q < CHAR_W'(2)) begin
            sum_chars_d[char_pos_q[0]] = b;
            char_pos_d                 = char_pos_q + CHAR_W'(1);
          end
          if (b == CH_CR) begin
            phase_d = PH_CLOSE;
          end
        end
        PH_CLOSE: begin
          rsum_d = rsum;
          if (rsum != running_xor_q) begin
            bad_sum_d = 1'b1;
            kind_d    = KIND_BAD_SUM;
          end else begin
            bad_sum_d = 1'b0;
            if (head_length_q == HEAD_LEN_W'(HEAD_DEPTH) && head_chars_q == HDR_RMC) begin
              kind_d = KIND_RMC;
            end else if (head_length_q == HEAD_LEN_W'(HEAD_DEPTH) &&
                         head_chars_q == HDR_GGA) begin
              kind_d = KIND_GGA;
            end else begin
              kind_d = KIND_OTHER;
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end

    // Header capture saturates at one past the depth to mark a long first field.
    if (keep_head) begin
      if (head_length_q < HEAD_LEN_W'(HEAD_DEPTH)) begin
        head_chars_d[head_length_q] = b;
        head_length_d               = head_length_q + HEAD_LEN_W'(1);
      end else begin
        head_length_d = HEAD_LEN_W'(HEAD_DEPTH + 1);
      end
    end

    // Every result returns the framer to idle; only the sticky flag survives.
    if (gives_result) begin
      phase_d       = PH_IDLE;
      field_index_d = '0;
      char_pos_d    = '0;
      running_xor_d = 8'd0;
      sum_chars_d   = '0;
      head_chars_d  = '0;
      head_length_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      phase_q       <= PH_IDLE;
      field_index_q <= '0;
      char_pos_q    <= '0;
      running_xor_q <= 8'd0;
      sum_chars_q   <= '0;
      head_chars_q  <= '0;
      head_length_q <= '0;
      bad_sum_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (rx_accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        phase_q       <= phase_d;
        field_index_q <= field_index_d;
        char_pos_q    <= char_pos_d;
        running_xor_q <= running_xor_d;
        sum_chars_q   <= sum_chars_d;
        head_chars_q  <= head_chars_d;
        head_length_q <= head_length_d;
        bad_sum_q     <= bad_sum_d;
      end
      if (fire && gives_result) begin
        out_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (rx_accept) begin
      in_byte_q <= rx_byte_i;
    end
    if (fire && gives_result) begin
      kind_q <= kind_d;
      csum_q <= running_xor_q;
      rsum_q <= rsum_d;
    end
  end

  // The sticky flag is shown as it stands after the closing byte.
  logic sticky_q;
  always_ff @(posedge clk_i) begin
    if (fire && gives_result) begin
      sticky_q <= bad_sum_d;
    end
  end

  assign res_valid_o             = out_valid_q;
  assign sentence_kind_o         = kind_q;
  assign computed_sum_o          = csum_q;
  assign received_sum_o          = rsum_q;
  assign checksum_error_sticky_o = sticky_q;

endmodule

/* design/nsf_checker.sv */
// Port-level checker of the sentence framer and its bind to the top level.
`include "assert_macros.svh"

module nsf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       res_valid_o,
  input logic                       res_stall_i,
  input logic [nsf_pkg::KIND_W-1:0] sentence_kind_o,
  input logic [7:0]                 computed_sum_o,
  input logic [7:0]                 received_sum_o,
  input logic                       checksum_error_sticky_o
);
  import nsf_pkg::*;

  logic [KIND_W+16:0] res_payload;
  logic               res_held;
  logic               kind_ovf;
  logic               kind_bad;
  logic               kind_good;
  logic               sums_equal;

  assign res_payload = {sentence_kind_o, computed_sum_o, received_sum_o,
                        checksum_error_sticky_o};
  assign res_held    = res_valid_o && res_stall_i;
  assign kind_ovf    = res_valid_o && (sentence_kind_o == KIND_OVERFLOW);
  assign kind_bad    = res_valid_o && (sentence_kind_o == KIND_BAD_SUM);
  assign kind_good   = res_valid_o && (sentence_kind_o == KIND_RMC ||
                                       sentence_kind_o == KIND_GGA ||
                                       sentence_kind_o == KIND_OTHER);
  assign sums_equal  = (computed_sum_o == received_sum_o);

  // A stalled result transaction stays on the port unchanged.
  `NSF_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_held, res_valid_o && $stable(res_payload))

  // Overflow reports no received checksum.
  `NSF_ASSERT_IMPL(a_ovf_rsum, clk_i, rst_ni, kind_ovf, received_sum_o == 8'd0)

  // A bad checksum sets the sticky flag and the sums really differ.
  `NSF_ASSERT_IMPL(a_bad_sum, clk_i, rst_ni, kind_bad, checksum_error_sticky_o && !sums_equal)

  // A good sentence clears the sticky flag and the sums agree.
  `NSF_ASSERT_IMPL(a_good_sum, clk_i, rst_ni, kind_good, !checksum_error_sticky_o && sums_equal)

  // Only the defined kinds appear.
  `NSF_ASSERT_IMPL(a_kind_range, clk_i, rst_ni, res_valid_o, sentence_kind_o <= KIND_OVERFLOW)

endmodule

bind nmea_sentence_framer_top nsf_checker u_nsf_checker (
  .clk_i                   (clk_i),
  .rst_ni                  (rst_ni),
  .res_valid_o             (res_valid_o),
  .res_stall_i             (res_stall_i),
  .sentence_kind_o         (sentence_kind_o),
  .computed_sum_o          (computed_sum_o),
  .received_sum_o          (received_sum_o),
  .checksum_error_sticky_o (checksum_error_sticky_o)
);
